/* src/hsv_to_rgb_converter_top_defines.svh */
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define H2R_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipeline check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define H2R_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipeline check failed one cycle later");

`endif

/* src/h2r_pkg.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, arithmetic constants, sector codes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int HUE_W      = 16;
    localparam int PCT_W      = 7;
    localparam int CHAN_W     = 8;
    localparam int SECTOR_W   = 3;
    localparam int OFFS_W     = 6;
    localparam int NUM_STAGES = 7;

    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [9:0]       HUE_FULL   = 10'd360;
    localparam logic [8:0]       SECTOR_DEG = 9'd60;

    // Reciprocals: floor(x*R>>k) = floor(x/d) where used; hue's may be 1 low.
    localparam logic [7:0]  HUE_RECIP = 8'd182;
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam logic [10:0] SEC_RECIP = 11'd1093;
    localparam logic [14:0] ADJ_RECIP = 15'd17477;

    localparam logic [SECTOR_W-1:0] SEC_RED_YEL  = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYAN = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYAN_BLU = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG  = 3'd4;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } h2r_ctrl_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [OFFS_W-1:0]   offs;
        logic [CHAN_W-1:0]   hi;
        logic [CHAN_W-1:0]   lo;
    } h2r_mid_t;

endpackage

/* src/h2r_channels.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter channels
// Valid/ready interfaces for the pixel input and the colour output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface h2r_in_if;
    import h2r_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface h2r_out_if;
    import h2r_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* src/h2r_flow_ctrl.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter flow control
// Valid bits of every stage and the load enables that collapse bubbles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_top_defines.svh"

module h2r_flow_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output h2r_pkg::h2r_ctrl_t ctrl
);
    import h2r_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    logic                  in_fire;
    logic                  out_fire;

    // A stage may load when it is empty or when its contents move on.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign ctrl.load = load;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    `H2R_ASSERT_NEXT(a_accept_enters, in_fire, valid_reg[0])
    `H2R_ASSERT_NOW(a_full_stall_blocks, (&valid_reg) && !out_ready, !in_ready)
    `H2R_ASSERT_NEXT(a_occupancy, 1'b1,
        $countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(in_fire)) - int'($past(out_fire)))

endmodule

/* src/h2r_front.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter front stages
// Clamping, hue reduction, sector split and the brightest and dimmest levels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_front (
    input  logic                        clk,
    input  h2r_pkg::h2r_ctrl_t          ctrl,
    input  logic [h2r_pkg::HUE_W-1:0]   hue,
    input  logic [h2r_pkg::PCT_W-1:0]   saturation,
    input  logic [h2r_pkg::PCT_W-1:0]   brightness,
    output h2r_pkg::h2r_mid_t           mid
);
    import h2r_pkg::*;

    // First stage: clamp, value times 255, coarse hue quotient.
    logic [PCT_W-1:0]  sat_clamp;
    logic [PCT_W-1:0]  bri_clamp;
    logic [23:0]       hue_prod;
    logic [HUE_W-1:0]  hue_a_reg;
    logic [7:0]        quot_a_reg;
    logic [7:0]        quot_a_next;
    logic [PCT_W-1:0]  sat_a_reg;
    logic [14:0]       vx_a_reg;
    logic [14:0]       vx_a_next;

    // Second stage: hue remainder below 720, brightest level.
    logic [16:0]       hue_base;
    logic [HUE_W-1:0]  hue_rem;
    logic [27:0]       hi_prod;
    logic [9:0]        hmod_b_reg;
    logic [9:0]        hmod_b_next;
    logic [CHAN_W-1:0] hi_b_reg;
    logic [CHAN_W-1:0] hi_b_next;
    logic [PCT_W-1:0]  sat_b_reg;

    // Third stage: hue below 360, dimmest level product.
    logic [9:0]        hmod_fix;
    logic [PCT_W-1:0]  dim_pct;
    logic [8:0]        hdeg_c_reg;
    logic [8:0]        hdeg_c_next;
    logic [CHAN_W-1:0] hi_c_reg;
    logic [14:0]       loprod_c_reg;
    logic [14:0]       loprod_c_next;

    // Fourth stage: sector, offset and dimmest level.
    logic [27:0]       lo_prod;
    logic [19:0]       sec_prod;
    logic [SECTOR_W-1:0] sector;
    logic [8:0]        sec_base;
    logic [8:0]        offs_full;
    h2r_mid_t          mid_reg;
    h2r_mid_t          mid_next;

    always_comb
    begin
        sat_clamp   = (saturation > PCT_FULL) ? PCT_FULL : saturation;
        bri_clamp   = (brightness > PCT_FULL) ? PCT_FULL : brightness;
        vx_a_next   = {bri_clamp, 8'd0} - {8'd0, bri_clamp};
        hue_prod    = {8'd0, hue} * {16'd0, HUE_RECIP};
        quot_a_next = hue_prod[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            hue_a_reg  <= hue;
            quot_a_reg <= quot_a_next;
            sat_a_reg  <= sat_clamp;
            vx_a_reg   <= vx_a_next;
        end
    end

    always_comb
    begin
        hue_base    = {9'd0, quot_a_reg} * {7'd0, HUE_FULL};
        hue_rem     = hue_a_reg - hue_base[HUE_W-1:0];
        hmod_b_next = hue_rem[9:0];
        hi_prod     = {13'd0, vx_a_reg} * {15'd0, PCT_RECIP};
        hi_b_next   = hi_prod[26:19];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            hmod_b_reg <= hmod_b_next;
            hi_b_reg   <= hi_b_next;
            sat_b_reg  <= sat_a_reg;
        end
    end

    always_comb
    begin
        hmod_fix      = (hmod_b_reg >= HUE_FULL) ? (hmod_b_reg - HUE_FULL) : hmod_b_reg;
        hdeg_c_next   = hmod_fix[8:0];
        dim_pct       = PCT_FULL - sat_b_reg;
        loprod_c_next = {7'd0, hi_b_reg} * {8'd0, dim_pct};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            hdeg_c_reg   <= hdeg_c_next;
            hi_c_reg     <= hi_b_reg;
            loprod_c_reg <= loprod_c_next;
        end
    end

    always_comb
    begin
        lo_prod         = {13'd0, loprod_c_reg} * {15'd0, PCT_RECIP};
        sec_prod        = {11'd0, hdeg_c_reg} * {9'd0, SEC_RECIP};
        sector          = sec_prod[18:16];
        sec_base        = {6'd0, sector} * SECTOR_DEG;
        offs_full       = hdeg_c_reg - sec_base;
        mid_next.sector = sector;
        mid_next.offs   = offs_full[OFFS_W-1:0];
        mid_next.hi     = hi_c_reg;
        mid_next.lo     = lo_prod[26:19];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

/* src/h2r_back.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter back stages
// Ramp offset within the sector, channel selection and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_back (
    input  logic                        clk,
    input  h2r_pkg::h2r_ctrl_t          ctrl,
    input  h2r_pkg::h2r_mid_t           mid,
    output logic [h2r_pkg::CHAN_W-1:0]  red,
    output logic [h2r_pkg::CHAN_W-1:0]  green,
    output logic [h2r_pkg::CHAN_W-1:0]  blue
);
    import h2r_pkg::*;

    logic [CHAN_W-1:0]   span;
    logic [13:0]         adjprod_e_reg;
    logic [13:0]         adjprod_e_next;
    logic [SECTOR_W-1:0] sector_e_reg;
    logic [CHAN_W-1:0]   hi_e_reg;
    logic [CHAN_W-1:0]   lo_e_reg;

    logic [28:0]         adj_prod;
    logic [CHAN_W-1:0]   adj_f_reg;
    logic [CHAN_W-1:0]   adj_f_next;
    logic [SECTOR_W-1:0] sector_f_reg;
    logic [CHAN_W-1:0]   hi_f_reg;
    logic [CHAN_W-1:0]   lo_f_reg;

    logic [CHAN_W-1:0]   rise;
    logic [CHAN_W-1:0]   fall;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   red_next;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   green_next;
    logic [CHAN_W-1:0]   blue_reg;
    logic [CHAN_W-1:0]   blue_next;

    always_comb
    begin
        span           = mid.hi - mid.lo;
        adjprod_e_next = {6'd0, span} * {8'd0, mid.offs};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            adjprod_e_reg <= adjprod_e_next;
            sector_e_reg  <= mid.sector;
            hi_e_reg      <= mid.hi;
            lo_e_reg      <= mid.lo;
        end
    end

    always_comb
    begin
        adj_prod   = {15'd0, adjprod_e_reg} * {14'd0, ADJ_RECIP};
        adj_f_next = adj_prod[27:20];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            adj_f_reg    <= adj_f_next;
            sector_f_reg <= sector_e_reg;
            hi_f_reg     <= hi_e_reg;
            lo_f_reg     <= lo_e_reg;
        end
    end

    always_comb
    begin
        rise = lo_f_reg + adj_f_reg;
        fall = hi_f_reg - adj_f_reg;
        case (sector_f_reg)
            SEC_RED_YEL:
            begin
                red_next = hi_f_reg; green_next = rise; blue_next = lo_f_reg;
            end
            SEC_YEL_GRN:
            begin
                red_next = fall; green_next = hi_f_reg; blue_next = lo_f_reg;
            end
            SEC_GRN_CYAN:
            begin
                red_next = lo_f_reg; green_next = hi_f_reg; blue_next = rise;
            end
            SEC_CYAN_BLU:
            begin
                red_next = lo_f_reg; green_next = fall; blue_next = hi_f_reg;
            end
            SEC_BLU_MAG:
            begin
                red_next = rise; green_next = lo_f_reg; blue_next = hi_f_reg;
            end
            default:
            begin
                red_next = hi_f_reg; green_next = lo_f_reg; blue_next = fall;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

/* src/hsv_to_rgb_converter_top.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Converts a hue, saturation and value triple to an 8-bit RGB triple.
// ---------------------------------------------------------------------------
// The converter accepts one transaction per clock unless all stages are full
// and the output stalls. Results leave in order through a seven-stage pipeline
// whose last stage is the output register. Every division by a constant is a
// reciprocal multiplication. The multiplies are spread over the stages so that
// no path holds more than one wide multiply. The hue is reduced in the first
// three stages, alongside the brightest and dimmest levels. The sector and its
// offset are found in the fourth, and the ramp step in the fifth and sixth.
// The seventh stage selects the channels. This spread is what sets the depth.
// Back-pressure from the output stalls only the stages that are full, so
// bubbles are squeezed out and input is refused only when all stages hold data.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    h2r_in_if.sink      pixel_in,
    h2r_out_if.source   pixel_out
);
    import h2r_pkg::*;

    h2r_ctrl_t ctrl;
    h2r_mid_t  mid;

    h2r_flow_ctrl u_flow_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_in.valid),
        .in_ready  (pixel_in.ready),
        .out_valid (pixel_out.valid),
        .out_ready (pixel_out.ready),
        .ctrl      (ctrl)
    );

    h2r_front u_front (
        .clk        (clk),
        .ctrl       (ctrl),
        .hue        (pixel_in.hue),
        .saturation (pixel_in.saturation),
        .brightness (pixel_in.brightness),
        .mid        (mid)
    );

    h2r_back u_back (
        .clk   (clk),
        .ctrl  (ctrl),
        .mid   (mid),
        .red   (pixel_out.red),
        .green (pixel_out.green),
        .blue  (pixel_out.blue)
    );

endmodule

/* tb/hsv_to_rgb_converter_top_tb.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives hue, saturation and value transactions into the converter and checks
// every colour transaction against a bit-exact integer prediction. Named test
// tasks cover the directed corner cases, random pixels under three handshake
// idling mixes and a pause that drains the pipeline completely.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_tb;
    import h2r_pkg::*;

    localparam int unsigned CHAN_MAX    = 255;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PRINT_CAP   = 40;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        hsv_t pixel;
        rgb_t colour;
    } colour_expect_t;

    logic clk;
    logic rst_n;

    h2r_in_if  pixel_in ();
    h2r_out_if pixel_out ();

    hsv_to_rgb_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_in),
        .pixel_out (pixel_out)
    );

    colour_expect_t colour_expected_q[$];
    int             mismatch_count;
    int             pixels_sent;
    int             colours_checked;
    int             cycle_count;
    int             send_idle_pct;
    int             recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic rgb_t hsv_to_rgb_predict(input hsv_t px);
        int unsigned         h;
        int unsigned         s;
        int unsigned         v;
        int unsigned         hi;
        int unsigned         lo;
        int unsigned         adj;
        int unsigned         offs;
        int unsigned         r;
        int unsigned         g;
        int unsigned         b;
        logic [SECTOR_W-1:0] sector;
        rgb_t                res;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        if (s > PCT_FULL)
            s = PCT_FULL;
        if (v > PCT_FULL)
            v = PCT_FULL;
        h      = h % HUE_FULL;
        sector = SECTOR_W'(h / SECTOR_DEG);
        offs   = h % SECTOR_DEG;
        hi     = v * CHAN_MAX / PCT_FULL;
        lo     = hi * (PCT_FULL - s) / PCT_FULL;
        adj    = (hi - lo) * offs / SECTOR_DEG;
        case (sector)
            SEC_RED_YEL:
            begin
                r = hi; g = lo + adj; b = lo;
            end
            SEC_YEL_GRN:
            begin
                r = hi - adj; g = hi; b = lo;
            end
            SEC_GRN_CYAN:
            begin
                r = lo; g = hi; b = lo + adj;
            end
            SEC_CYAN_BLU:
            begin
                r = lo; g = hi - adj; b = hi;
            end
            SEC_BLU_MAG:
            begin
                r = lo + adj; g = lo; b = hi;
            end
            default:
            begin
                r = hi; g = lo; b = hi - adj;
            end
        endcase
        res.red   = CHAN_W'(r);
        res.green = CHAN_W'(g);
        res.blue  = CHAN_W'(b);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sender: entered just after a rising edge; leaves valid high after acceptance.
    task automatic send_pixel(input hsv_t px);
        colour_expect_t entry;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_in.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_in.valid      <= 1'b1;
        pixel_in.hue        <= px.hue;
        pixel_in.saturation <= px.saturation;
        pixel_in.brightness <= px.brightness;
        @(posedge clk);
        while (!pixel_in.ready)
            @(posedge clk);
        entry.pixel  = px;
        entry.colour = hsv_to_rgb_predict(px);
        colour_expected_q.push_back(entry);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        pixel_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic hsv_t random_pixel();
        hsv_t px;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            px.hue = HUE_W'($urandom_range(0, 359));
        else if (pick < 85)
            px.hue = HUE_W'($urandom);
        else
            px.hue = HUE_W'(60 * $urandom_range(0, 12) + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 99) < 70)
            px.saturation = PCT_W'($urandom_range(0, 100));
        else
            px.saturation = PCT_W'($urandom);
        if ($urandom_range(0, 99) < 70)
            px.brightness = PCT_W'($urandom_range(0, 100));
        else
            px.brightness = PCT_W'($urandom);
        return px;
    endfunction

    task automatic test_corner_pixels();
        hsv_t corners[$];
        corners = '{
            '{16'd0,     7'd100, 7'd100}, '{16'd59,    7'd100, 7'd100},
            '{16'd60,    7'd100, 7'd100}, '{16'd119,   7'd100, 7'd100},
            '{16'd120,   7'd100, 7'd100}, '{16'd180,   7'd100, 7'd100},
            '{16'd240,   7'd100, 7'd100}, '{16'd300,   7'd100, 7'd100},
            '{16'd359,   7'd100, 7'd100}, '{16'd360,   7'd100, 7'd100},
            '{16'd65535, 7'd100, 7'd100}, '{16'd45,    7'd0,   7'd100},
            '{16'd200,   7'd0,   7'd57},  '{16'd90,    7'd127, 7'd100},
            '{16'd150,   7'd101, 7'd80},  '{16'd210,   7'd60,  7'd127},
            '{16'd270,   7'd40,  7'd101}, '{16'd330,   7'd75,  7'd0},
            '{16'd30,    7'd127, 7'd127}, '{16'd0,     7'd0,   7'd0},
            '{16'd65400, 7'd50,  7'd50},  '{16'd719,   7'd33,  7'd66},
            '{16'd135,   7'd99,  7'd1},   '{16'd255,   7'd1,   7'd99}
        };
        foreach (corners[i])
            send_pixel(corners[i]);
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    task automatic test_drain_pause();
        test_random_pixels(20);
        stop_sending();
        while (colour_expected_q.size() != 0)
            @(posedge clk);
        test_random_pixels(20);
    endtask

    // Receiver: random back-pressure and checking of every accepted transaction.
    initial
    begin
        colour_expect_t entry;
        pixel_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_out.valid && pixel_out.ready)
            begin
                if (colour_expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected colour %02h %02h %02h",
                                    pixel_out.red, pixel_out.green, pixel_out.blue));
                else
                begin
                    entry = colour_expected_q.pop_front();
                    colours_checked++;
                    if (pixel_out.red !== entry.colour.red)
                        report_mismatch($sformatf("hsv %0d/%0d/%0d red %0d, expected %0d",
                                        entry.pixel.hue, entry.pixel.saturation,
                                        entry.pixel.brightness, pixel_out.red,
                                        entry.colour.red));
                    if (pixel_out.green !== entry.colour.green)
                        report_mismatch($sformatf("hsv %0d/%0d/%0d green %0d, expected %0d",
                                        entry.pixel.hue, entry.pixel.saturation,
                                        entry.pixel.brightness, pixel_out.green,
                                        entry.colour.green));
                    if (pixel_out.blue !== entry.colour.blue)
                        report_mismatch($sformatf("hsv %0d/%0d/%0d blue %0d, expected %0d",
                                        entry.pixel.hue, entry.pixel.saturation,
                                        entry.pixel.brightness, pixel_out.blue,
                                        entry.colour.blue));
                end
            end
            pixel_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles.", cycle_count);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count      = 0;
        pixels_sent         = 0;
        colours_checked     = 0;
        send_idle_pct       = 17;
        recv_idle_pct       = 79;
        rst_n               = 1'b0;
        pixel_in.valid      <= 1'b0;
        pixel_in.hue        <= '0;
        pixel_in.saturation <= '0;
        pixel_in.brightness <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_pixels();
        test_random_pixels(240);

        send_idle_pct = 79;
        recv_idle_pct = 17;
        test_random_pixels(240);
        test_drain_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(230);

        stop_sending();
        while (colour_expected_q.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_STAGES) @(posedge clk);

        $display("Sent %0d pixels, corner cases and random, under three handshake mixes.",
                 pixels_sent);
        $display("Checked %0d colour transactions, including a full pipeline drain.",
                 colours_checked);
        if (mismatch_count == 0 && colour_expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/h2r_pkg.sv
src/h2r_channels.sv
src/h2r_flow_ctrl.sv
src/h2r_front.sv
src/h2r_back.sv
src/hsv_to_rgb_converter_top.sv
tb/hsv_to_rgb_converter_top_tb.sv
